/* design/afd_pkg.sv */
package afd_pkg;

    localparam int SampleW = 13;
    localparam int TimeW   = 32;
    localparam int VelW    = 32;
    localparam int CfgIdxW = 3;

    localparam logic [TimeW-1:0] LockoutMs      = 32'd1000;
    localparam logic [TimeW-1:0] HighCrossReset = 32'd1500;
    localparam logic [4:0]       StillRun       = 5'd25;

    localparam logic [CfgIdxW-1:0] RegRestZ     = 3'd0;
    localparam logic [CfgIdxW-1:0] RegStillBand = 3'd1;
    localparam logic [CfgIdxW-1:0] RegLowLevel  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegHighLevel = 3'd3;
    localparam logic [CfgIdxW-1:0] RegGapLimit  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegSpeedSq   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegCosAngle  = 3'd6;

    // multiplier operand selects, one product per sequencer step
    typedef enum logic [3:0] {
        MUL_SX, MUL_SY, MUL_SZ, MUL_DX, MUL_DY, MUL_DZ,
        MUL_VX, MUL_VY, MUL_VZ, MUL_LO, MUL_HI, MUL_COS, MUL_A, MUL_BM
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SX, ST_SY, ST_SZ, ST_DX, ST_DY, ST_DZ,
        ST_VX, ST_VY, ST_VZ, ST_LO, ST_HI, ST_COS, ST_A, ST_BM, ST_OUT
    } t_state;

    typedef struct packed {
        logic [11:0] rest_z;
        logic [11:0] still_band;
        logic [12:0] low_level;
        logic [12:0] high_level;
        logic [31:0] gap_limit;
        logic [63:0] speed_limit_sq;
        logic signed [15:0] cos_angle;
    } t_cfg;

endpackage

/* design/afd_mul.sv */
// shared signed multiplier, registered product
module afd_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

/* design/accel_fall_detector.sv */
// One sample at a time: the single shared multiplier takes one product per
// step of the sequence ST_SX to ST_BM, and ST_OUT then registers the result.
// s_axis_tready stays low until the result is taken.
// Reset (synchronous, active low) restores register defaults and detector state.
module accel_fall_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // sample_x, sample_y, sample_z, now_ms, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // fall_detected, speed_alarm, impact_alarm,
                                        // tilt_alarm, zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    afd_pkg::t_cfg   r_cfg;
    afd_pkg::t_state r_state, n_state;
    afd_pkg::t_mul_sel w_sel;

    logic signed [12:0] r_x, r_y, r_z;
    logic [31:0] r_now;
    logic signed [31:0] r_vx, r_vy, r_vz;
    logic [4:0]  r_still;
    logic [31:0] r_last;
    logic        r_bl, r_bh;
    logic [31:0] r_lct, r_hct, r_at;
    logic [63:0] r_acc;   // m, then sum of velocity squares
    logic [63:0] r_m;
    logic [27:0] r_lo2;   // low_level^2
    logic [27:0] r_hi2;
    logic [31:0] r_b2;    // cos^2
    logic [63:0] r_a2;
    logic        r_ox, r_oy, r_oz, r_sp, r_im, r_ti;
    logic [3:0]  w_out;
    logic        r_ovalid;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_p;
    logic [31:0] w_dt;
    logic signed [13:0] w_dz;

    assign w_dt = r_now - r_last;
    assign w_dz = 14'(r_z) - $signed({2'b00, r_cfg.rest_z});

    afd_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_p));

    assign s_axis_tready = (r_state == afd_pkg::ST_IDLE) && !r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, w_out};

    // step that issues each product; product is read in the next step
    always_comb begin
        n_state = r_state;
        case (r_state)
            afd_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = afd_pkg::ST_SX;
            afd_pkg::ST_OUT:  n_state = afd_pkg::ST_IDLE;
            default:          n_state = afd_pkg::t_state'(r_state + 4'd1);
        endcase
    end

    always_comb begin
        w_sel = afd_pkg::MUL_SX;
        case (r_state)
            afd_pkg::ST_SX: w_sel = afd_pkg::MUL_SX;
            afd_pkg::ST_SY: w_sel = afd_pkg::MUL_SY;
            afd_pkg::ST_SZ: w_sel = afd_pkg::MUL_SZ;
            afd_pkg::ST_DX: w_sel = afd_pkg::MUL_DX;
            afd_pkg::ST_DY: w_sel = afd_pkg::MUL_DY;
            afd_pkg::ST_DZ: w_sel = afd_pkg::MUL_DZ;
            afd_pkg::ST_VX: w_sel = afd_pkg::MUL_VX;
            afd_pkg::ST_VY: w_sel = afd_pkg::MUL_VY;
            afd_pkg::ST_VZ: w_sel = afd_pkg::MUL_VZ;
            afd_pkg::ST_LO: w_sel = afd_pkg::MUL_LO;
            afd_pkg::ST_HI: w_sel = afd_pkg::MUL_HI;
            afd_pkg::ST_COS: w_sel = afd_pkg::MUL_COS;
            afd_pkg::ST_A:  w_sel = afd_pkg::MUL_A;
            afd_pkg::ST_BM: w_sel = afd_pkg::MUL_BM;
            default: w_sel = afd_pkg::MUL_SX;
        endcase
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (w_sel)
            afd_pkg::MUL_SX: begin w_ma = 33'(r_x); w_mb = 33'(r_x); end
            afd_pkg::MUL_SY: begin w_ma = 33'(r_y); w_mb = 33'(r_y); end
            afd_pkg::MUL_SZ: begin w_ma = 33'(r_z); w_mb = 33'(r_z); end
            afd_pkg::MUL_DX: begin w_ma = 33'(r_x); w_mb = $signed({1'b0, w_dt}); end
            afd_pkg::MUL_DY: begin w_ma = 33'(r_y); w_mb = $signed({1'b0, w_dt}); end
            afd_pkg::MUL_DZ: begin w_ma = 33'(w_dz); w_mb = $signed({1'b0, w_dt}); end
            afd_pkg::MUL_VX: begin w_ma = 33'(r_vx); w_mb = 33'(r_vx); end
            afd_pkg::MUL_VY: begin w_ma = 33'(r_vy); w_mb = 33'(r_vy); end
            afd_pkg::MUL_VZ: begin w_ma = 33'(r_vz); w_mb = 33'(r_vz); end
            afd_pkg::MUL_LO: begin
                w_ma = $signed({20'd0, r_cfg.low_level});
                w_mb = w_ma;
            end
            afd_pkg::MUL_HI: begin
                w_ma = $signed({20'd0, r_cfg.high_level});
                w_mb = w_ma;
            end
            afd_pkg::MUL_COS: begin w_ma = 33'(r_cfg.cos_angle); w_mb = w_ma; end
            afd_pkg::MUL_A:   begin w_ma = 33'(r_z); w_mb = 33'(r_z); end
            // m < 2^26 and cos^2 <= 2^30: product fits 56 bits
            afd_pkg::MUL_BM: begin
                w_ma = $signed({1'b0, r_b2});
                w_mb = $signed({7'd0, r_m[25:0]});
            end
            default: ;
        endcase
    end

    function automatic logic signed [31:0] sat32(input logic signed [65:0] s);
        if (s > 66'sd2147483647) return 32'sh7FFF_FFFF;
        if (s < -66'sd2147483648) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    logic [27:0] w_lo1sq, w_hi1sq;
    logic        w_lock, w_bl_cross, w_bh_cross;
    logic [31:0] w_lct, w_hct;
    logic [63:0] w_bm;

    // (L+1)^2 = L^2 + 2L + 1
    assign w_lo1sq = r_lo2 + {14'd0, r_cfg.low_level, 1'b0} + 28'd1;
    assign w_hi1sq = r_hi2 + {14'd0, r_cfg.high_level, 1'b0} + 28'd1;
    assign w_lock = (r_now - r_at) <= afd_pkg::LockoutMs;
    assign w_bl_cross = r_bl && ({2'b00, r_m[25:0]} >= w_lo1sq);
    assign w_bh_cross = r_bh && ({2'b00, r_m[25:0]} >= w_hi1sq);
    assign w_lct = w_bl_cross ? r_now : r_lct;
    assign w_hct = w_bh_cross ? r_now : r_hct;
    assign w_bm  = w_p[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= afd_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_cfg.rest_z <= 12'd256;
            r_cfg.still_band <= 12'd16;
            r_cfg.low_level <= 13'd128;
            r_cfg.high_level <= 13'd512;
            r_cfg.gap_limit <= 32'd500;
            r_cfg.speed_limit_sq <= 64'd1000000000;
            r_cfg.cos_angle <= 16'sd23170;
            r_vx <= '0; r_vy <= '0; r_vz <= '0;
            r_still <= '0;
            r_last <= '0;
            r_bl <= 1'b1; r_bh <= 1'b1;
            r_lct <= '0; r_hct <= afd_pkg::HighCrossReset; r_at <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    afd_pkg::RegRestZ:     r_cfg.rest_z <= i_cfg_data[11:0];
                    afd_pkg::RegStillBand: r_cfg.still_band <= i_cfg_data[11:0];
                    afd_pkg::RegLowLevel:  r_cfg.low_level <= i_cfg_data[12:0];
                    afd_pkg::RegHighLevel: r_cfg.high_level <= i_cfg_data[12:0];
                    afd_pkg::RegGapLimit:  r_cfg.gap_limit <= i_cfg_data[31:0];
                    afd_pkg::RegSpeedSq:   r_cfg.speed_limit_sq <= i_cfg_data;
                    afd_pkg::RegCosAngle:  r_cfg.cos_angle <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                afd_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_x <= s_axis_tdata[12:0];
                    r_y <= s_axis_tdata[25:13];
                    r_z <= s_axis_tdata[38:26];
                    r_now <= s_axis_tdata[70:39];
                end
                afd_pkg::ST_SX: begin
                    r_ox <= ((r_x < 0) ? -14'(r_x) : 14'(r_x)) > $signed({2'b0, r_cfg.still_band});
                    r_oy <= ((r_y < 0) ? -14'(r_y) : 14'(r_y)) > $signed({2'b0, r_cfg.still_band});
                    r_oz <= ((w_dz < 0) ? -w_dz : w_dz) > $signed({2'b0, r_cfg.still_band});
                end
                afd_pkg::ST_SY: r_acc <= w_p[63:0];
                afd_pkg::ST_SZ: r_acc <= r_acc + w_p[63:0];
                afd_pkg::ST_DX: begin
                    r_m <= r_acc + w_p[63:0];
                    if (!r_ox && !r_oy && !r_oz) begin
                        if (r_still + 5'd1 > afd_pkg::StillRun) begin
                            r_still <= '0;
                            r_vx <= '0; r_vy <= '0; r_vz <= '0;
                        end else begin
                            r_still <= r_still + 5'd1;
                        end
                    end else begin
                        r_still <= '0;
                    end
                end
                afd_pkg::ST_DY: if (r_ox) r_vx <= sat32(66'(r_vx) + w_p);
                afd_pkg::ST_DZ: if (r_oy) r_vy <= sat32(66'(r_vy) + w_p);
                afd_pkg::ST_VX: begin
                    if (r_oz) r_vz <= sat32(66'(r_vz) + w_p);
                    r_last <= r_now;
                end
                afd_pkg::ST_VY: r_acc <= w_p[63:0];
                afd_pkg::ST_VZ: r_acc <= r_acc + w_p[63:0];
                afd_pkg::ST_LO: r_sp <= (r_acc + w_p[63:0]) > r_cfg.speed_limit_sq;
                afd_pkg::ST_HI: r_lo2 <= w_p[27:0];
                afd_pkg::ST_COS: begin
                    r_hi2 <= w_p[27:0];
                end
                afd_pkg::ST_A: begin
                    r_b2 <= w_p[31:0];
                    // impact check, crossing thresholds built from the level squares
                    r_im <= 1'b0;
                    if (r_sp && !w_lock) begin
                        r_lct <= w_lct;
                        r_hct <= w_hct;
                        r_bl <= {38'd0, r_m[25:0]} < {36'd0, r_lo2};
                        r_bh <= {38'd0, r_m[25:0]} < {36'd0, r_hi2};
                        if ((w_hct - w_lct) < r_cfg.gap_limit
                            && (r_now - w_hct) <= afd_pkg::LockoutMs) begin
                            r_at <= r_now;
                            r_im <= 1'b1;
                        end
                    end
                end
                afd_pkg::ST_BM: r_a2 <= {w_p[33:0], 30'd0};   // (z*32768)^2
                afd_pkg::ST_OUT: begin
                    if (r_m == 64'd0 || r_cfg.rest_z == 12'd0 || !r_im) begin
                        r_ti <= 1'b0;
                    end else if (r_cfg.cos_angle > 0) begin
                        r_ti <= (r_z < 0) || (r_a2 < w_bm);
                    end else if (r_cfg.cos_angle == 0) begin
                        r_ti <= (r_z < 0);
                    end else begin
                        r_ti <= (r_z < 0) && (r_a2 > w_bm);
                    end
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign w_out = {r_ti, r_im, r_sp, r_sp && r_im && r_ti};

endmodule
